// ===== hdl/fhmc_pkg.sv =====
package fhmc_pkg;

  localparam int HEADER_BYTES = 512;
  localparam int CNT_W        = $clog2(HEADER_BYTES + 1);
  localparam int ADDR_W       = $clog2(HEADER_BYTES);

  // leading bytes held in flops for the fixed-offset checks
  localparam int CAP_BYTES    = 28;
  localparam int CAP_IDX_W    = $clog2(CAP_BYTES);

  // position of the 32-bit pe header pointer
  localparam int PE_PTR_POS   = 60;
  localparam int PE_PTR_END   = PE_PTR_POS + 4;

  localparam logic [2:0] FMT_UNKNOWN = 3'd0;
  localparam logic [2:0] FMT_HEX     = 3'd1;
  localparam logic [2:0] FMT_ELF     = 3'd2;
  localparam logic [2:0] FMT_PE      = 3'd3;
  localparam logic [2:0] FMT_MACHO   = 3'd4;
  localparam logic [2:0] FMT_COFF    = 3'd5;

  localparam logic [6:0] SCORE_NONE = 7'd0;
  localparam logic [6:0] SCORE_MZ   = 7'd25;
  localparam logic [6:0] SCORE_OFF  = 7'd40;
  localparam logic [6:0] SCORE_FULL = 7'd100;

  localparam logic [31:0] MAGIC_CAFE   = 32'hCAFEBABE;
  localparam logic [31:0] MAGIC_MACH32 = 32'hFEEDFACE;
  localparam logic [31:0] MAGIC_MACH64 = 32'hFEEDFACF;
  localparam logic [31:0] FAT_ARCH_MAX = 32'd30;

  // byte arrays, element 0 is the first byte in the file
  localparam logic [7:0][7:0] AR_MAGIC   = {8'h0A, 8'h3E, 8'h68, 8'h63,
                                            8'h72, 8'h61, 8'h3C, 8'h21};
  localparam logic [7:0][7:0] THIN_MAGIC = {8'h0A, 8'h3E, 8'h6E, 8'h69,
                                            8'h68, 8'h74, 8'h3C, 8'h21};
  localparam logic [15:0][7:0] BIGOBJ_GUID = {
    8'hB8, 8'hDC, 8'hA4, 8'h6A, 8'hF6, 8'hFA, 8'h20, 8'hAF,
    8'h4B, 8'hA9, 8'hBA, 8'hEE, 8'hD1, 8'hBA, 8'hA1, 8'hC7};
  localparam logic [3:0][7:0] PE_SIG = {8'h00, 8'h00, 8'h45, 8'h50};

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  format_code;
    logic [6:0]  pe_score;
    logic [6:0]  elf_score;
    logic [6:0]  hex_score;
    logic [6:0]  thin_macho_score;
    logic [6:0]  coff_score;
    logic [6:0]  archive_score;
    logic [31:0] fat_second_word;
    logic [6:0]  java_score;
    logic [6:0]  fat_macho_score;
  } out_item_t;

  typedef struct packed {
    logic [CAP_BYTES-1:0][7:0] head;
    logic [3:0][7:0]           pe_ptr;
    logic [CNT_W-1:0]          size;
    logic                      sig_ok;
  } eval_in_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_DECIDE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } fhmc_state_t;

  function automatic logic coff_machine_known(input logic [15:0] m);
    logic hit;
    unique case (m)
      16'h014C, 16'h014D, 16'h014E, 16'h0184, 16'h01A2, 16'h01A3, 16'h01A4,
      16'h01A6, 16'h01A8, 16'h01C0, 16'h01C2, 16'h01C4, 16'h01D3, 16'h01F0,
      16'h0200, 16'h0268, 16'h0290, 16'h0284, 16'h0160, 16'h0162, 16'h0163,
      16'h0166, 16'h0140, 16'h0142, 16'h0266, 16'h0168, 16'h0169, 16'h0366,
      16'h0466, 16'h0520, 16'h0EBC, 16'h8664, 16'h9041, 16'hAA64,
      16'hC0EE: hit = 1'b1;
      default:  hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== hdl/fhmc_store.sv =====
module fhmc_store
  import fhmc_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [HEADER_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/fhmc_eval.sv =====
module fhmc_eval
  import fhmc_pkg::*;
(
  input  eval_in_t  ev,
  output logic      pe_probe,
  output out_item_t res
);

  logic [31:0] le_word;
  logic [31:0] be_word;
  logic [31:0] w_word;
  logic [31:0] pe_off;
  logic        ge2, ge4, ge8, ge28, ge_ptr;
  logic        is_hex, is_elf, is_mz, is_ar, thin_magic, is_cafe;
  logic        coff_mach, bigobj, off_fits, off_inside, cafe8;

  always_comb begin
    ge2    = ev.size >= CNT_W'(2);
    ge4    = ev.size >= CNT_W'(4);
    ge8    = ev.size >= CNT_W'(8);
    ge28   = ev.size >= CNT_W'(CAP_BYTES);
    ge_ptr = ev.size >= CNT_W'(PE_PTR_END);

    le_word = {ev.head[3], ev.head[2], ev.head[1], ev.head[0]};
    be_word = {ev.head[0], ev.head[1], ev.head[2], ev.head[3]};
    w_word  = {ev.head[4], ev.head[5], ev.head[6], ev.head[7]};
    pe_off  = ev.pe_ptr;

    is_hex = (ev.size != '0) && (ev.head[0] == 8'h3A);
    is_elf = ge4 && (le_word == 32'h464C457F);
    is_mz  = ge2 && (((ev.head[0] == 8'h4D) && (ev.head[1] == 8'h5A)) ||
                     ((ev.head[0] == 8'h5A) && (ev.head[1] == 8'h4D)));
    is_ar  = ge8 && ((ev.head[7:0] == AR_MAGIC) || (ev.head[7:0] == THIN_MAGIC));
    thin_magic = ge4 && ((le_word == MAGIC_MACH32) || (le_word == MAGIC_MACH64) ||
                         (be_word == MAGIC_MACH32) || (be_word == MAGIC_MACH64));
    is_cafe   = ge4 && ((le_word == MAGIC_CAFE) || (be_word == MAGIC_CAFE));
    cafe8     = is_cafe && ge8;
    coff_mach = ge2 && coff_machine_known({ev.head[1], ev.head[0]});
    bigobj    = ge28 && (ev.head[27:12] == BIGOBJ_GUID);

    // wide compare so an offset near the top of the range does not wrap
    off_fits   = ({1'b0, pe_off} + 33'd4) <= 33'(ev.size);
    off_inside = pe_off < 32'(ev.size);
    pe_probe   = is_mz && ge_ptr && off_fits;

    res.hex_score        = is_hex ? SCORE_FULL : SCORE_NONE;
    res.elf_score        = is_elf ? SCORE_FULL : SCORE_NONE;
    res.thin_macho_score = thin_magic ? SCORE_FULL : SCORE_NONE;
    res.coff_score       = (coff_mach || bigobj) ? SCORE_FULL : SCORE_NONE;
    res.archive_score    = is_ar ? SCORE_FULL : SCORE_NONE;

    res.pe_score = SCORE_NONE;
    if (is_mz) begin
      res.pe_score = SCORE_MZ;
      if (ge_ptr) begin
        if (off_fits && ev.sig_ok) begin
          res.pe_score = SCORE_FULL;
        end else if (off_inside) begin
          res.pe_score = SCORE_OFF;
        end
      end
    end

    res.fat_second_word = cafe8 ? w_word : 32'd0;
    res.java_score      = (cafe8 && (w_word > FAT_ARCH_MAX)) ? SCORE_FULL : SCORE_NONE;
    res.fat_macho_score = (cafe8 && (w_word <= FAT_ARCH_MAX)) ? SCORE_FULL : SCORE_NONE;

    priority if (!ge4) begin
      res.format_code = is_hex ? FMT_HEX : FMT_UNKNOWN;
    end else if (is_hex) begin
      res.format_code = FMT_HEX;
    end else if (is_elf) begin
      res.format_code = FMT_ELF;
    end else if (is_mz) begin
      res.format_code = FMT_PE;
    end else if (is_ar) begin
      res.format_code = FMT_UNKNOWN;
    end else if (thin_magic) begin
      res.format_code = FMT_MACHO;
    end else if (is_cafe) begin
      res.format_code = (cafe8 && (w_word <= FAT_ARCH_MAX)) ? FMT_MACHO : FMT_UNKNOWN;
    end else if (coff_mach || bigobj) begin
      res.format_code = FMT_COFF;
    end else begin
      res.format_code = FMT_UNKNOWN;
    end
  end

endmodule

// ===== hdl/file_header_magic_classifier.sv =====
// file header magic classifier
// input channel: one header byte per beat with a last-byte mark, file order
// output channel: one verdict beat per file, format code plus family scores
// both channels use valid/stall; a beat moves when valid is high and stall low
// bytes of a file stream in at one per cycle; the first HEADER_BYTES go to the header ram,
// later bytes are dropped but still accepted
// after the last byte the block stalls its input for the finishing work: a decide
//   state, then the done state when no pe signature probe is needed, or four read
//   states and a drain state before done when it reads the four bytes at the pe
//   pointer from the ram (one read port, one byte a cycle)
// the verdict beat then sits in the output register; the next file's bytes are
// taken while it waits, but a second verdict waits until the first is taken
// reset clears the byte count, the state and the output valid; the ram keeps
// whatever it holds, only bytes written for the current file are ever read
module file_header_magic_classifier
  import fhmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  fhmc_state_t state_r, state_nxt;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          size_r;
  logic [CAP_BYTES-1:0][7:0] head_r;
  logic [3:0][7:0]           pe_ptr_r;
  logic [1:0]                rd_idx_r, rd_idx_nxt;
  logic [1:0]                chk_idx_r, chk_idx_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic                      sig_ok_r, sig_ok_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r;

  logic              in_beat;
  logic              room;
  logic              out_load;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              pe_probe;
  eval_in_t          ev;
  out_item_t         res;

  assign in_stall  = (state_r != ST_FILL);
  assign in_beat   = in_valid && !in_stall;
  assign room      = count_r < CNT_W'(HEADER_BYTES);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // bytes past the ram depth are accepted and dropped
  fhmc_store u_store (
    .clk     (clk),
    .wr_en   (in_beat && room),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (in_data.byte_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // pointer is known to fit inside the stored bytes when probing, so no wrap
  assign rd_addr = ADDR_W'(pe_ptr_r) + ADDR_W'(rd_idx_r);

  assign ev.head   = head_r;
  assign ev.pe_ptr = pe_ptr_r;
  assign ev.size   = size_r;
  assign ev.sig_ok = sig_ok_r;

  fhmc_eval u_eval (
    .ev       (ev),
    .pe_probe (pe_probe),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      count_r     <= '0;
      rd_idx_r    <= '0;
      chk_idx_r   <= '0;
      rd_pend_r   <= 1'b0;
      sig_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_idx_r   <= chk_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      sig_ok_r    <= sig_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // leading bytes and the pe pointer are caught in flops as they stream by
  always_ff @(posedge clk) begin
    if (in_beat) begin
      if (count_r < CNT_W'(CAP_BYTES)) begin
        head_r[count_r[CAP_IDX_W-1:0]] <= in_data.byte_value;
      end
      for (int k = 0; k < 4; k++) begin
        if (count_r == CNT_W'(PE_PTR_POS + k)) begin
          pe_ptr_r[k] <= in_data.byte_value;
        end
      end
      if (in_data.last_byte) begin
        size_r <= room ? count_r + CNT_W'(1) : count_r;
      end
    end
    if (out_load) begin
      out_item_r <= res;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    chk_idx_nxt   = chk_idx_r;
    rd_pend_nxt   = 1'b0;
    sig_ok_nxt    = sig_ok_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    // check the byte whose read was issued last cycle
    if (rd_pend_r && (rd_data != PE_SIG[chk_idx_r])) begin
      sig_ok_nxt = 1'b0;
    end

    unique case (state_r)
      ST_FILL: begin
        if (in_beat) begin
          if (in_data.last_byte) begin
            count_nxt = '0;
            state_nxt = ST_DECIDE;
          end else if (room) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      ST_DECIDE: begin
        rd_idx_nxt = '0;
        if (pe_probe) begin
          sig_ok_nxt = 1'b1;
          state_nxt  = ST_READ;
        end else begin
          sig_ok_nxt = 1'b0;
          state_nxt  = ST_DONE;
        end
      end
      ST_READ: begin
        rd_pend_nxt = 1'b1;
        chk_idx_nxt = rd_idx_r;
        rd_idx_nxt  = rd_idx_r + 2'd1;
        if (rd_idx_r == 2'd3) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // verdict waits here only while an older one is still stalled
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_FILL;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import fhmc_pkg::*;

  localparam int CYCLE_LIMIT    = 200_000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_BYTES   = 100;
  localparam int DRAIN_CYCLES   = 20;
  localparam int FAT_ARCH_LIMIT = 30;

  // coff machine ids recognized by the classifier
  localparam logic [15:0] COFF_IDS [35] = '{
    16'h014C, 16'h014D, 16'h014E, 16'h0184, 16'h01A2, 16'h01A3, 16'h01A4,
    16'h01A6, 16'h01A8, 16'h01C0, 16'h01C2, 16'h01C4, 16'h01D3, 16'h01F0,
    16'h0200, 16'h0268, 16'h0290, 16'h0284, 16'h0160, 16'h0162, 16'h0163,
    16'h0166, 16'h0140, 16'h0142, 16'h0266, 16'h0168, 16'h0169, 16'h0366,
    16'h0466, 16'h0520, 16'h0EBC, 16'h8664, 16'h9041, 16'hAA64, 16'hC0EE};

  // bigobj class id, stored at byte 12 of the file
  localparam logic [7:0] BIGOBJ_ID [16] = '{
    8'hC7, 8'hA1, 8'hBA, 8'hD1, 8'hEE, 8'hBA, 8'hA9, 8'h4B,
    8'hAF, 8'h20, 8'hFA, 8'hF6, 8'h6A, 8'hA4, 8'hDC, 8'hB8};

  // keeps its own copy of the header, predicts one verdict per file and
  // checks the verdict beats in order
  class verdict_scoreboard;
    logic [7:0]  hdr [HEADER_BYTES];
    int unsigned fill;
    out_item_t   want_q[$];
    int unsigned errors;
    int unsigned seen;

    function new();
      fill   = 0;
      errors = 0;
      seen   = 0;
    endfunction

    function bit hdr_has(string s, int unsigned at, int unsigned size);
      if (size < at + s.len()) return 1'b0;
      foreach (s[i]) if (hdr[at + i] != s[i]) return 1'b0;
      return 1'b1;
    endfunction

    function out_item_t classify(int unsigned size);
      logic [31:0] le, be, w, off;
      bit          is_hex, is_elf, is_mz, is_cafe, macho, mach_hit, bigobj;
      out_item_t   r;
      r  = '0;
      le = '0;
      be = '0;
      w  = '0;
      is_hex = size >= 1 && hdr[0] == ":";
      is_elf = size >= 4 && hdr[0] == 8'h7F && hdr_has("ELF", 1, size);
      is_mz  = hdr_has("MZ", 0, size) || hdr_has("ZM", 0, size);
      if (hdr_has("!<arch>\n", 0, size) || hdr_has("!<thin>\n", 0, size))
        r.archive_score = SCORE_FULL;
      if (size >= 4) begin
        le = {hdr[3], hdr[2], hdr[1], hdr[0]};
        be = {hdr[0], hdr[1], hdr[2], hdr[3]};
      end
      macho = size >= 4 && (le == 32'hFEEDFACE || le == 32'hFEEDFACF ||
                            be == 32'hFEEDFACE || be == 32'hFEEDFACF);
      is_cafe = size >= 4 && (le == 32'hCAFEBABE || be == 32'hCAFEBABE);
      if (size >= 8) w = {hdr[4], hdr[5], hdr[6], hdr[7]};
      mach_hit = 1'b0;
      if (size >= 2)
        foreach (COFF_IDS[i]) if (COFF_IDS[i] == {hdr[1], hdr[0]}) mach_hit = 1'b1;
      bigobj = size >= 28;
      if (bigobj)
        foreach (BIGOBJ_ID[i]) if (hdr[12 + i] != BIGOBJ_ID[i]) bigobj = 1'b0;

      r.hex_score        = is_hex ? SCORE_FULL : SCORE_NONE;
      r.elf_score        = is_elf ? SCORE_FULL : SCORE_NONE;
      r.thin_macho_score = macho ? SCORE_FULL : SCORE_NONE;
      r.coff_score       = (mach_hit || bigobj) ? SCORE_FULL : SCORE_NONE;

      if (is_mz) begin
        r.pe_score = SCORE_MZ;
        if (size >= 64) begin
          off = {hdr[63], hdr[62], hdr[61], hdr[60]};
          // wide compare so an offset near the top of the range cannot wrap
          if ({32'b0, off} + 64'd4 <= 64'(size) && hdr[off] == "P" &&
              hdr[off + 1] == "E" && hdr[off + 2] == 8'h00 && hdr[off + 3] == 8'h00)
            r.pe_score = SCORE_FULL;
          else if (off < size)
            r.pe_score = SCORE_OFF;
        end
      end

      if (is_cafe && size >= 8) begin
        r.fat_second_word = w;
        if (w > FAT_ARCH_LIMIT) r.java_score = SCORE_FULL;
        else r.fat_macho_score = SCORE_FULL;
      end

      if (size < 4) r.format_code = is_hex ? FMT_HEX : FMT_UNKNOWN;
      else if (is_hex) r.format_code = FMT_HEX;
      else if (is_elf) r.format_code = FMT_ELF;
      else if (is_mz) r.format_code = FMT_PE;
      else if (r.archive_score != SCORE_NONE) r.format_code = FMT_UNKNOWN;
      else if (macho) r.format_code = FMT_MACHO;
      else if (is_cafe)
        r.format_code = (r.fat_macho_score != SCORE_NONE) ? FMT_MACHO : FMT_UNKNOWN;
      else if (mach_hit || bigobj) r.format_code = FMT_COFF;
      else r.format_code = FMT_UNKNOWN;
      return r;
    endfunction

    // accepted input beat: store it if there is room, predict on the mark
    function void note_byte(in_item_t b);
      if (fill < HEADER_BYTES) begin
        hdr[fill] = b.byte_value;
        fill++;
      end
      if (b.last_byte) begin
        want_q.push_back(classify(fill));
        fill = 0;
      end
    endfunction

    function int diff_field(string name, logic [31:0] e, logic [31:0] g, bit report);
      if (e === g) return 0;
      if (report) $display("verdict %0d %s: expected %0d, got %0d", seen, name, e, g);
      return 1;
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t exp;
      bit        report;
      int        nbad;
      seen++;
      report = errors < 10;
      if (want_q.size() == 0) begin
        errors++;
        if (report) $display("verdict %0d arrived with none pending", seen);
        return;
      end
      exp  = want_q.pop_front();
      nbad = diff_field("format_code", exp.format_code, got.format_code, report)
           + diff_field("pe_score", exp.pe_score, got.pe_score, report)
           + diff_field("elf_score", exp.elf_score, got.elf_score, report)
           + diff_field("hex_score", exp.hex_score, got.hex_score, report)
           + diff_field("thin_macho_score", exp.thin_macho_score,
                        got.thin_macho_score, report)
           + diff_field("coff_score", exp.coff_score, got.coff_score, report)
           + diff_field("archive_score", exp.archive_score, got.archive_score, report)
           + diff_field("fat_second_word", exp.fat_second_word,
                        got.fat_second_word, report)
           + diff_field("java_score", exp.java_score, got.java_score, report)
           + diff_field("fat_macho_score", exp.fat_macho_score,
                        got.fat_macho_score, report);
      if (nbad != 0) errors++;
    endfunction

    // verdicts that never showed up
    function void close();
      if (want_q.size() != 0) begin
        if (errors < 10) $display("%0d verdicts never arrived", want_q.size());
        errors += want_q.size();
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  verdict_scoreboard sb = new();

  // bytes of the file being built, sent as one burst of beats
  logic [7:0] pend_bytes[$];

  // no random idling on either side while set
  bit calm      = 1'b0;
  // toggled by the sender to ask the receiver for one long hold-off
  bit hold_req  = 1'b0;
  bit hold_ack  = 1'b0;
  int hold_left = 0;
  int cycle_count;

  file_header_magic_classifier uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // both channels are sampled at the rising edge; input beats are noted
  // first so a verdict can never overtake the byte that caused it
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_data);
      if (out_valid && !out_stall) sb.check_verdict(out_data);
    end
  end

  // receiver: random stalls, plus one long hold-off counted here so the
  // output register fills and the block has to stall its input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 8);
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic put_str(string s);
    foreach (s[i]) pend_bytes.push_back(s[i]);
  endtask

  task automatic put_rand(int n);
    repeat (n) pend_bytes.push_back(8'($urandom_range(255)));
  endtask

  // 32-bit word, little or big endian
  task automatic put_word(logic [31:0] w, bit big_end);
    for (int i = 0; i < 4; i++)
      pend_bytes.push_back(big_end ? w[31 - 8*i -: 8] : w[8*i +: 8]);
  endtask

  task automatic put_pe_sig();
    put_str("PE");
    pend_bytes.push_back(8'h00);
    pend_bytes.push_back(8'h00);
  endtask

  task automatic put_guid(int n);
    for (int i = 0; i < n; i++) pend_bytes.push_back(BIGOBJ_ID[i]);
  endtask

  // one input beat; entered and left at a falling edge so every drive
  // change lands on a falling edge, away from the sampling edge
  task automatic send_beat(logic [7:0] v, bit l);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{byte_value: v, last_byte: l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // whole file, mark on the final byte
  task automatic send_file();
    int n;
    n = pend_bytes.size();
    for (int i = 0; i < n; i++) send_beat(pend_bytes[i], i == n - 1);
    pend_bytes.delete();
  endtask

  initial begin
    int          kind, len, k;
    int unsigned random_bytes;
    logic [31:0] off, w;
    random_bytes = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed files ----
    // lone colon: intel hex with under four bytes
    put_str(":");
    send_file();
    // single other byte: unknown
    put_str("Z");
    send_file();
    // two-byte mz: verdict unknown but pe score set
    put_str("MZ");
    send_file();
    // two-byte coff machine: score without verdict
    put_word(32'h0000014C, 1'b0);
    void'(pend_bytes.pop_back());
    void'(pend_bytes.pop_back());
    send_file();
    // extremes of the byte value
    put_word(32'hFFFFFFFF, 1'b0);
    send_file();
    put_word(32'h00000000, 1'b0);
    send_file();
    // intel hex and elf
    put_str(":");
    put_rand(10);
    send_file();
    pend_bytes.push_back(8'h7F);
    put_str("ELF");
    put_rand(12);
    send_file();
    // pointer close to the top of the range, no wrap allowed
    put_str("MZ");
    put_rand(58);
    put_word(32'hFFFFFFFE, 1'b0);
    send_file();
    // mz one byte short of the pointer field
    put_str("MZ");
    put_rand(61);
    send_file();
    // archives
    put_str("!<arch>\n");
    put_rand(4);
    send_file();
    put_str("!<thin>\n");
    send_file();
    // thin mach-o, both byte orders and both magics
    put_word(32'hFEEDFACE, 1'b1);
    send_file();
    put_word(32'hFEEDFACF, 1'b0);
    put_rand(4);
    send_file();
    // cafebabe around the fat/java split
    put_word(32'hCAFEBABE, 1'b1);
    put_word(32'd30, 1'b1);
    send_file();
    put_word(32'hCAFEBABE, 1'b1);
    put_word(32'd31, 1'b1);
    send_file();
    put_word(32'hCAFEBABE, 1'b0);
    put_word(32'h12345678, 1'b1);
    send_file();
    // cafebabe too short for the second word
    put_word(32'hCAFEBABE, 1'b1);
    put_rand(2);
    send_file();
    // amd64 coff
    put_word(32'h00008664, 1'b0);
    void'(pend_bytes.pop_back());
    void'(pend_bytes.pop_back());
    put_rand(30);
    send_file();
    // bigobj id, exactly long enough and one byte short
    put_word(32'hFFFF0000, 1'b0);
    put_rand(8);
    put_guid(16);
    send_file();
    put_word(32'hFFFF0000, 1'b0);
    put_rand(8);
    put_guid(15);
    send_file();
    // longer than the store: signature in the last stored bytes, then
    // bytes that must be dropped; sent as one long stretch with no idling
    calm <= 1'b1;
    put_str("MZ");
    put_rand(58);
    put_word(32'd508, 1'b0);
    put_rand(444);
    put_pe_sig();
    put_rand(8);
    send_file();
    calm <= 1'b0;

    // ---- random files ----
    // long receiver hold-off while small files keep coming
    hold_req <= ~hold_ack;
    while (random_bytes < RANDOM_BYTES) begin
      kind = $urandom_range(9);
      case (kind)
        0: put_rand($urandom_range(1, 24));
        1: begin
          put_str(":");
          put_rand($urandom_range(0, 20));
        end
        2: begin
          pend_bytes.push_back(8'h7F);
          put_str("ELF");
          put_rand($urandom_range(0, 20));
        end
        3: begin
          len = $urandom_range(68, 110);
          if ($urandom_range(1) != 0) put_str("MZ");
          else put_str("ZM");
          put_rand(58);
          k = $urandom_range(4);
          case (k)
            0: off = $urandom_range(64, len - 4);
            1: off = $urandom_range(0, len - 1);
            2: off = $urandom_range(len, 600);
            3: off = $urandom();
            default: off = len - $urandom_range(1, 3);
          endcase
          put_word(off, 1'b0);
          put_rand(len - 64);
          if (k == 0) begin
            pend_bytes[off]     = "P";
            pend_bytes[off + 1] = "E";
            pend_bytes[off + 2] = 8'h00;
            pend_bytes[off + 3] = 8'h00;
          end
        end
        4: begin
          if ($urandom_range(1) != 0) put_str("!<arch>\n");
          else put_str("!<thin>\n");
          put_rand($urandom_range(0, 12));
        end
        5: begin
          put_word($urandom_range(1) ? 32'hFEEDFACE : 32'hFEEDFACF,
                   1'($urandom_range(1)));
          put_rand($urandom_range(0, 16));
        end
        6: begin
          put_word(32'hCAFEBABE, 1'($urandom_range(1)));
          w = $urandom_range(1) ? 32'($urandom_range(0, 40)) : $urandom();
          put_word(w, 1'b1);
          len = $urandom_range(4, 16);
          while (pend_bytes.size() > len) void'(pend_bytes.pop_back());
        end
        7: begin
          w = {16'h0, COFF_IDS[$urandom_range(34)]};
          pend_bytes.push_back(w[7:0]);
          pend_bytes.push_back(w[15:8]);
          put_rand($urandom_range(0, 30));
        end
        8: begin
          put_word(32'hFFFF0000, 1'b0);
          put_rand(8);
          put_guid(16);
          // now and then a corrupted id byte
          if ($urandom_range(3) == 0) pend_bytes[12 + $urandom_range(15)] ^= 8'h01;
          put_rand($urandom_range(0, 10));
        end
        default: begin
          // truncated magic prefixes
          case ($urandom_range(3))
            0: put_str(":");
            1: put_str("M");
            2: pend_bytes.push_back(8'h7F);
            default: pend_bytes.push_back(8'hCA);
          endcase
          put_rand($urandom_range(0, 2));
        end
      endcase
      random_bytes += (pend_bytes.size() > HEADER_BYTES) ? HEADER_BYTES : pend_bytes.size();
      send_file();
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // drain, then allow for the longest finishing read
    while (sb.want_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.close();
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/fhmc_pkg.sv
hdl/fhmc_store.sv
hdl/fhmc_eval.sv
hdl/file_header_magic_classifier.sv
dv/tb.sv
